// ===== rtl/slot_allocator_with_reuse_delay_macros.svh =====
// Assertion macros for the slot allocator with reuse delay.
`ifndef SLOT_ALLOCATOR_WITH_REUSE_DELAY_MACROS_SVH
`define SLOT_ALLOCATOR_WITH_REUSE_DELAY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/salloc_pkg.sv =====
// Package of types and constants for the slot allocator with reuse delay.
`default_nettype none

package salloc_pkg;

  localparam int SLOT_W = 10;
  localparam int CFG_W  = 32;
  localparam int TICK_W = 32;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_REUSED   = 2'd0,
    ST_EXTENDED = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  localparam logic [1:0] CFG_FIRST_SLOT = 2'd0;
  localparam logic [1:0] CFG_STARTUP    = 2'd1;
  localparam logic [1:0] CFG_GRACE      = 2'd2;

  localparam logic [SLOT_W-1:0] FIRST_SLOT_RST = 10'd9;
  localparam logic [CFG_W-1:0]  STARTUP_RST    = 32'd2000;
  localparam logic [CFG_W-1:0]  GRACE_RST      = 32'd500;

endpackage

`default_nettype wire

// ===== rtl/salloc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module salloc_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/slot_allocator_with_reuse_delay.sv =====
// Top level of the first-fit slot allocator with reuse delay.
// A word is taken when start is high and busy is low. For a free,
// its result shows in the next cycle and busy stays low. An allocate scans the
// slot memory through its single read port, one slot a cycle, up to the scan
// end when no slot qualifies and stopping early on a hit; busy is high
// meanwhile. The result is shown on out_valid for exactly one cycle and cannot
// be held off. After reset a clearing pass writes every slot once with busy
// high; configuration writes are taken throughout.
`include "slot_allocator_with_reuse_delay_macros.svh"
`default_nettype none

module slot_allocator_with_reuse_delay
  import salloc_pkg::*;
#(
  parameter int SLOTS     = 1024,
  parameter int TIME_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_opcode,
  input  wire logic [SLOT_W-1:0] in_slot_index,
  input  wire logic [TICK_W-1:0] in_now_ticks,
  output logic                   out_valid,
  output logic      [SLOT_W-1:0] out_granted_slot,
  output logic      [1:0]        out_status,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;
  localparam int TW = TIME_BITS;
  localparam int MW = TW + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]     issue_r, issue_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [AW-1:0]     chk_addr_r, chk_addr_nxt;
  logic [CW-1:0]     end_r, end_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [TW-1:0]     now_r, now_nxt;
  logic [CW-1:0]     hw_r, hw_nxt;
  logic [SLOT_W-1:0] first_slot_r;
  logic [TW-1:0]     startup_r;
  logic [TW-1:0]     grace_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [MW-1:0]     ram_wdata;
  logic              ram_re;
  logic [MW-1:0]     ram_rdata;

  logic              accept;
  logic [CW-1:0]     fs_ext;
  logic [CW-1:0]     count_eff;
  logic [CW-1:0]     scan_end;
  logic [CW-1:0]     idx_ext;
  logic              free_bad;
  logic [TW-1:0]     now_in;
  logic              rd_mark;
  logic [TW-1:0]     rd_time;
  logic              slot_ok;

  salloc_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign fs_ext    = CW'(first_slot_r);
  assign count_eff = (hw_r > fs_ext) ? hw_r : fs_ext;
  assign scan_end  = (count_eff > CW'(SLOTS)) ? CW'(SLOTS) : count_eff;
  assign idx_ext   = CW'(in_slot_index);
  assign free_bad  = (idx_ext < fs_ext) || (idx_ext >= count_eff) || (idx_ext >= CW'(SLOTS));
  assign now_in    = TW'(in_now_ticks);
  assign rd_mark   = ram_rdata[TW];
  assign rd_time   = ram_rdata[TW-1:0];
  assign slot_ok   = rd_mark &&
                     ((rd_time < startup_r) ||
                      ((now_r > rd_time) && ((now_r - rd_time) > grace_r)));

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    issue_nxt      = issue_r;
    chk_v_nxt      = chk_v_r;
    chk_addr_nxt   = chk_addr_r;
    end_nxt        = end_r;
    count_nxt      = count_r;
    now_nxt        = now_r;
    hw_nxt         = hw_r;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        if (clr_addr_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_FREE) begin
            out_valid_nxt = 1'b1;
            out_slot_nxt  = in_slot_index;
            if (free_bad) begin
              out_status_nxt = ST_BAD;
            end else begin
              out_status_nxt = ST_REUSED;
              ram_we         = 1'b1;
              ram_waddr      = AW'(in_slot_index);
              ram_wdata      = {1'b1, now_in};
            end
          end else begin
            issue_nxt = fs_ext;
            chk_v_nxt = 1'b0;
            end_nxt   = scan_end;
            count_nxt = count_eff;
            now_nxt   = now_in;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        priority if (chk_v_r && slot_ok) begin
          ram_we         = 1'b1;
          ram_waddr      = chk_addr_r;
          ram_wdata      = {1'b0, rd_time};
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = SLOT_W'(chk_addr_r);
          out_status_nxt = ST_REUSED;
          chk_v_nxt      = 1'b0;
          state_nxt      = S_IDLE;
        end else if (issue_r < end_r) begin
          ram_re       = 1'b1;
          chk_v_nxt    = 1'b1;
          chk_addr_nxt = issue_r[AW-1:0];
          issue_nxt    = issue_r + CW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          chk_v_nxt     = 1'b0;
          state_nxt     = S_IDLE;
          if (count_r >= CW'(SLOTS)) begin
            out_slot_nxt   = '0;
            out_status_nxt = ST_FULL;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = count_r[AW-1:0];
            ram_wdata      = '0;
            hw_nxt         = count_r + CW'(1);
            out_slot_nxt   = SLOT_W'(count_r);
            out_status_nxt = ST_EXTENDED;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      chk_v_r      <= 1'b0;
      hw_r         <= '0;
      first_slot_r <= FIRST_SLOT_RST;
      startup_r    <= TW'(STARTUP_RST);
      grace_r      <= TW'(GRACE_RST);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      chk_v_r     <= chk_v_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIRST_SLOT: first_slot_r <= cfg_wdata[SLOT_W-1:0];
          CFG_STARTUP:    startup_r    <= TW'(cfg_wdata);
          CFG_GRACE:      grace_r      <= TW'(cfg_wdata);
          default:        ;
        endcase
      end
    end
    issue_r      <= issue_nxt;
    chk_addr_r   <= chk_addr_nxt;
    end_r        <= end_nxt;
    count_r      <= count_nxt;
    now_r        <= now_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

  `SA_ASSERT_NEXT(a_result_source, !busy && !start, !out_valid_r, "result strobe without a word")
  `SA_ASSERT_NOW(a_no_result_in_clear, state_r == S_CLEAR, !out_valid_r, "strobe while clearing")
  `SA_ASSERT_NOW(a_hw_bound, 1'b1, hw_r <= CW'(SLOTS), "high-water count beyond capacity")
  `SA_ASSERT_NEXT(a_scan_ends_in_idle, out_valid_nxt && state_r == S_SCAN, !busy, "scan left busy")

endmodule

`default_nettype wire
